// ===== rtl/core/clsrng_pkg.sv =====
// Shared constants and types for the combined LCG shuffle generator.
// Used by the Schrage step unit and the top level; depends on nothing.

package clsrng_pkg;

   localparam int unsigned TABLE_SIZE_DEF = 32;
   localparam int unsigned WARMUP         = 8;

   // First generator: multiplier, modulus, Schrage quotient and remainder.
   localparam logic [15:0] MUL1 = 16'd40014;
   localparam logic [30:0] MOD1 = 31'd2147483563;
   localparam logic [15:0] QUO1 = 16'd53668;
   localparam logic [13:0] REM1 = 14'd12211;

   // Second generator.
   localparam logic [15:0] MUL2 = 16'd40692;
   localparam logic [30:0] MOD2 = 31'd2147483399;
   localparam logic [15:0] QUO2 = 16'd52774;
   localparam logic [13:0] REM2 = 14'd3791;

   localparam logic [30:0] FIRST_INIT  = 31'd1;
   localparam logic [30:0] SECOND_INIT = 31'd123456789;
   localparam logic [30:0] WRAP_ADD    = 31'd2147483562;

   // One value moving into or out of a Schrage step unit.
   typedef struct packed {
      logic        valid;
      logic [30:0] value;
   } gen_beat_type;

endpackage

// ===== rtl/core/clsrng_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.

module clsrng_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/clsrng_schrage.sv =====
// Three-stage Schrage step unit: x -> (MUL * x) mod MOD without a wide divider.
// Uses clsrng_pkg for the beat type and default constants.

module clsrng_schrage
   import clsrng_pkg::*;
#(
   parameter logic [15:0] MUL = MUL1,
   parameter logic [15:0] QUO = QUO1,
   parameter logic [13:0] REM = REM1,
   parameter logic [30:0] MOD = MOD1
) (
   input  logic         clock,
   input  logic         reset,
   input  gen_beat_type step_in,
   output gen_beat_type step_out
);

   // Reciprocal of the quotient constant; the estimate it gives is low by at most one.
   localparam logic [16:0] RCP = 17'((64'd1 << 32) / 64'(QUO));

   logic        v1_ff, v2_ff, v3_ff;
   logic [30:0] x_ff;
   logic [47:0] prod_ff, prod_in;
   logic [15:0] k_ff, k_in;
   logic [15:0] r_ff, r_in;
   logic [30:0] res_ff, res_in;

   logic [15:0] k_est;
   logic [31:0] kq;
   logic [31:0] diff;
   logic [32:0] ar;
   logic [32:0] kr;
   logic [32:0] t;

   assign prod_in = 48'(step_in.value) * 48'(RCP);

   always_comb begin
      k_est = prod_ff[47:32];
      kq    = 32'(k_est) * 32'(QUO);
      diff  = 32'(x_ff) - kq;
      if (diff >= 32'(QUO)) begin
         k_in = k_est + 16'd1;
         r_in = 16'(diff - 32'(QUO));
      end else begin
         k_in = k_est;
         r_in = diff[15:0];
      end
   end

   always_comb begin
      ar = 33'(r_ff) * 33'(MUL);
      kr = 33'(k_ff) * 33'(REM);
      t  = ar - kr;
      if (t[32]) begin
         t = t + 33'(MOD);
      end
      res_in = t[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= step_in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_in.valid) begin
         x_ff    <= step_in.value;
         prod_ff <= prod_in;
      end
      if (v1_ff) begin
         k_ff <= k_in;
         r_ff <= r_in;
      end
      if (v2_ff) begin
         res_ff <= res_in;
      end
   end

   assign step_out.valid = v3_ff;
   assign step_out.value = res_ff;

endmodule

// ===== rtl/core/combined_lcg_shuffle_rng.sv =====
// Combined two-generator LCG with a Bays-Durham shuffle table; top level.
// Uses clsrng_pkg, clsrng_schrage (two instances) and clsrng_ram.
//
// Each request beat returns one sample beat in 1..2147483562, to be read as the
// fraction sample/2147483563. A draw runs through S_D0 to S_D3 from acceptance
// to the result register: both Schrage units run their three stages while the
// slot index is formed and the shuffle table is read, and S_D3 combines the
// values and writes the slot back. A reseed first steps the first generator
// TABLE_SIZE+8 times, each step waiting on the previous one through the Schrage
// unit, before its draw. One request is handled at a time; a finished sample
// waits in the output register, and a new request is taken while it waits.
// Table entries not yet written since reset read as zero.

module combined_lcg_shuffle_rng
   import clsrng_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [30:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_sample
);

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int CNT_W  = $clog2(TABLE_SIZE + WARMUP);
   localparam int RCP_W  = IDX_W + 2;
   localparam int EST_W  = IDX_W + 1;
   localparam int SP_W   = 31 + RCP_W;
   localparam int CHK_W  = 31 + EST_W;
   localparam logic [30:0] SLOT_DIV =
      31'(32'd1 + (32'(MOD1) - 32'd1) / 32'(TABLE_SIZE));
   localparam logic [RCP_W-1:0] SLOT_RCP = RCP_W'((64'd1 << 32) / 64'(SLOT_DIV));
   localparam logic [CNT_W-1:0] SEED_STEPS = CNT_W'(TABLE_SIZE + WARMUP - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SEED = 3'd1;
   localparam logic [2:0] S_D0   = 3'd2;
   localparam logic [2:0] S_D1   = 3'd3;
   localparam logic [2:0] S_D2   = 3'd4;
   localparam logic [2:0] S_D3   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [30:0]           gen1_ff, gen1_in;
   logic [30:0]           gen2_ff, gen2_in;
   logic [30:0]           last_out_ff, last_out_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [TABLE_SIZE-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [30:0]           sample_ff, sample_in;
   logic [EST_W-1:0]      est_ff, est_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic                  entry_ok_ff, entry_ok_in;

   gen_beat_type gen1_step, gen1_out;
   gen_beat_type gen2_step, gen2_out;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic             ram_rd_en;
   logic [30:0]      ram_rd_data;

   logic [SP_W-1:0]  slot_prod;
   logic [CHK_W-1:0] slot_chk;
   logic [CHK_W-1:0] slot_rem;
   logic [EST_W-1:0] slot_q;
   logic [30:0]      entry;
   logic [32:0]      y;
   logic [30:0]      seed_val;

   clsrng_schrage #(
      .MUL (MUL1),
      .QUO (QUO1),
      .REM (REM1),
      .MOD (MOD1)
   ) u_gen1 (
      .clock    (clock),
      .reset    (reset),
      .step_in  (gen1_step),
      .step_out (gen1_out)
   );

   clsrng_schrage #(
      .MUL (MUL2),
      .QUO (QUO2),
      .REM (REM2),
      .MOD (MOD2)
   ) u_gen2 (
      .clock    (clock),
      .reset    (reset),
      .step_in  (gen2_step),
      .step_out (gen2_out)
   );

   clsrng_ram #(
      .WIDTH (31),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (gen1_out.value),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign gen1_step.valid = (state_ff == S_SEED && !busy_ff) || state_ff == S_D0;
   assign gen1_step.value = gen1_ff;
   assign gen2_step.valid = (state_ff == S_D0);
   assign gen2_step.value = gen2_ff;

   // Slot index = last_out / SLOT_DIV, by reciprocal estimate and one correction.
   // last_out holds still from the first draw cycle on, so est and slot settle in turn.
   always_comb begin
      slot_prod = SP_W'(last_out_ff) * SP_W'(SLOT_RCP);
      est_in    = slot_prod[SP_W-1:32];
      slot_chk  = CHK_W'(est_ff) * CHK_W'(SLOT_DIV);
      slot_rem  = CHK_W'(last_out_ff) - slot_chk;
      slot_q    = (slot_rem >= CHK_W'(SLOT_DIV)) ? est_ff + EST_W'(1) : est_ff;
      if (slot_q >= EST_W'(TABLE_SIZE)) begin
         slot_in = IDX_W'(TABLE_SIZE - 1);
      end else begin
         slot_in = slot_q[IDX_W-1:0];
      end
   end

   always_comb begin
      entry    = entry_ok_ff ? ram_rd_data : '0;
      y        = 33'(entry) - 33'(gen2_out.value);
      if (y[32] || y == '0) begin
         y = y + 33'(WRAP_ADD);
      end
      seed_val = (req_seed == '0) ? 31'd1 : req_seed;
   end

   always_comb begin
      state_in     = state_ff;
      gen1_in      = gen1_ff;
      gen2_in      = gen2_ff;
      last_out_in  = last_out_ff;
      cnt_in       = cnt_ff;
      busy_in      = busy_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sample_in    = sample_ff;
      entry_ok_in  = entry_ok_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_ff;
      ram_rd_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action) begin
                  gen1_in  = seed_val;
                  gen2_in  = seed_val;
                  cnt_in   = SEED_STEPS;
                  busy_in  = 1'b0;
                  state_in = S_SEED;
               end else begin
                  state_in = S_D0;
               end
            end
         end
         S_SEED: begin
            if (gen1_out.valid) begin
               busy_in = 1'b0;
               gen1_in = gen1_out.value;
               // Only the last TABLE_SIZE steps land in the table, highest index first.
               if (cnt_ff < CNT_W'(TABLE_SIZE)) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = cnt_ff[IDX_W-1:0];
                  valid_in[cnt_ff[IDX_W-1:0]] = 1'b1;
               end
               if (cnt_ff == '0) begin
                  last_out_in = gen1_out.value;
                  state_in    = S_D0;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end else if (!busy_ff) begin
               busy_in = 1'b1;
            end
         end
         S_D0: begin
            state_in = S_D1;
         end
         S_D1: begin
            state_in = S_D2;
         end
         S_D2: begin
            ram_rd_en   = 1'b1;
            entry_ok_in = valid_ff[slot_ff];
            state_in    = S_D3;
         end
         S_D3: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               gen1_in          = gen1_out.value;
               gen2_in          = gen2_out.value;
               last_out_in      = y[30:0];
               ram_wr_en        = 1'b1;
               valid_in[slot_ff] = 1'b1;
               rsp_valid_in     = 1'b1;
               sample_in        = y[30:0];
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen1_ff      <= FIRST_INIT;
         gen2_ff      <= SECOND_INIT;
         last_out_ff  <= '0;
         cnt_ff       <= '0;
         busy_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen1_ff      <= gen1_in;
         gen2_ff      <= gen2_in;
         last_out_ff  <= last_out_in;
         cnt_ff       <= cnt_in;
         busy_ff      <= busy_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      est_ff      <= est_in;
      slot_ff     <= slot_in;
      entry_ok_ff <= entry_ok_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

   // A new sample only ever comes out of the final draw cycle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_D3)
      else $error("sample appeared outside the final draw cycle");

   // Both Schrage results must line up with the first combine cycle of a draw.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_D3 && $past(state_ff) == S_D2) |-> (gen1_out.valid && gen2_out.valid))
      else $error("generator results not ready when the draw combines them");

   // During reseed a generator result only arrives for a step that was issued.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEED && gen1_out.valid) |-> busy_ff)
      else $error("unexpected generator result during reseed");

   // The wrapped output never reaches zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> sample_ff != '0)
      else $error("sample out of range");

endmodule

// ===== tb/tb_combined_lcg_shuffle_rng.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for combined_lcg_shuffle_rng: random and directed draw/reseed beats.
// Depends only on the block's RTL; the expected samples come from a scoreboard class in this file.

module tb_combined_lcg_shuffle_rng;

   localparam int     TABLE_SLOTS  = 32;
   localparam int     WARMUP_STEPS = 8;
   localparam longint FIRST_MUL    = 40014;
   localparam longint FIRST_MOD    = 2147483563;
   localparam longint FIRST_QUO    = 53668;
   localparam longint FIRST_REM    = 12211;
   localparam longint SECOND_MUL   = 40692;
   localparam longint SECOND_MOD   = 2147483399;
   localparam longint SECOND_QUO   = 52774;
   localparam longint SECOND_REM   = 3791;
   localparam longint WRAP_SPAN    = FIRST_MOD - 1;
   localparam longint SLOT_SPAN    = 1 + (FIRST_MOD - 1) / TABLE_SLOTS;

   localparam bit [30:0] SECOND_START    = 31'd123456789;
   localparam bit [30:0] SEED_ALL_ONES   = 31'h7FFF_FFFF;
   localparam bit [30:0] SEED_FIRST_MOD  = 31'd2147483563;
   localparam bit [30:0] SEED_SECOND_MOD = 31'd2147483399;
   localparam bit [30:0] SEED_WRAP       = 31'd2147483562;

   localparam int GAP_MAX      = 18;
   localparam int RANDOM_ITEMS = 1950;
   localparam int TAIL_CYCLES  = 16;

   typedef enum bit {
      ACT_DRAW   = 1'b0,
      ACT_RESEED = 1'b1
   } action_type;

   // Tracks the generator state and the samples still owed by the block.
   class sample_tracker;
      bit [30:0]   first_gen;
      bit [30:0]   second_gen;
      bit [30:0]   last_sample;
      bit [30:0]   shuffle[TABLE_SLOTS];
      bit [30:0]   owed_samples[$];
      int unsigned mismatches;

      function void clear();
         first_gen   = 31'd1;
         second_gen  = SECOND_START;
         last_sample = 31'd0;
         foreach (shuffle[i]) shuffle[i] = 31'd0;
         owed_samples.delete();
         mismatches = 0;
      endfunction

      function bit [30:0] schrage(bit [30:0] x, longint mul, longint quo, longint rem,
                                  longint modulus);
         longint v;
         longint k;
         longint t;
         v = x;
         k = v / quo;
         t = mul * (v - k * quo) - k * rem;
         if (t < 0) t += modulus;
         return t[30:0];
      endfunction

      function bit [30:0] draw_sample();
         longint slot;
         longint diff;
         first_gen  = schrage(first_gen, FIRST_MUL, FIRST_QUO, FIRST_REM, FIRST_MOD);
         second_gen = schrage(second_gen, SECOND_MUL, SECOND_QUO, SECOND_REM, SECOND_MOD);
         slot = longint'(last_sample) / SLOT_SPAN;
         if (slot >= TABLE_SLOTS) slot = TABLE_SLOTS - 1;
         diff = longint'(shuffle[slot]) - longint'(second_gen);
         shuffle[slot] = first_gen;
         if (diff < 1) diff += WRAP_SPAN;
         last_sample = diff[30:0];
         return last_sample;
      endfunction

      // The table is filled from the top slot down after the warm-up steps.
      function void reseed(bit [30:0] seed);
         bit [30:0] s;
         s = (seed == 31'd0) ? 31'd1 : seed;
         first_gen  = s;
         second_gen = s;
         for (int n = TABLE_SLOTS + WARMUP_STEPS - 1; n >= 0; n--) begin
            first_gen = schrage(first_gen, FIRST_MUL, FIRST_QUO, FIRST_REM, FIRST_MOD);
            if (n < TABLE_SLOTS) shuffle[n] = first_gen;
         end
         last_sample = shuffle[0];
      endfunction

      function void note_request(action_type action, bit [30:0] seed);
         if (action == ACT_RESEED) reseed(seed);
         owed_samples.push_back(draw_sample());
      endfunction

      function void check_sample(logic [30:0] got);
         bit [30:0] want;
         if (owed_samples.size() == 0) begin
            $error("sample: expected no beat, actual %0d", got);
            mismatches++;
         end else begin
            want = owed_samples.pop_front();
            if (got !== want) begin
               $error("sample: expected %0d, actual %0d", want, got);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [30:0] req_seed   = 31'd0;
   logic        rsp_valid;
   logic        rsp_stall  = 1'b0;
   logic [30:0] rsp_sample;

   sample_tracker tracker;
   bit            quiet = 1'b0;

   combined_lcg_shuffle_rng i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_seed   (req_seed),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Valid stays high between beats when the next gap is zero.
   task automatic send_request(action_type action, bit [30:0] seed);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_seed   <= seed;
      do @(posedge clock); while (req_stall);
      tracker.note_request(action, seed);
   endtask

   // Valid is dropped first so the beat already taken is not offered again.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (tracker.owed_samples.size() != 0) @(posedge clock);
   endtask

   initial begin : sample_sink
      int hold;
      wait (tracker != null && !reset);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, GAP_MAX);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         tracker.check_sample(rsp_sample);
      end
   end

   initial begin : stimulus
      bit [31:0] r;
      tracker = new;
      tracker.clear();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Draws on the reset state, where the table still holds zeros.
      send_request(ACT_DRAW, 31'd0);
      send_request(ACT_DRAW, SEED_ALL_ONES);
      send_request(ACT_DRAW, 31'd12345);
      // A zero seed behaves as a seed of one.
      send_request(ACT_RESEED, 31'd0);
      send_request(ACT_DRAW, 31'd0);
      send_request(ACT_RESEED, 31'd1);
      send_request(ACT_DRAW, SEED_ALL_ONES);
      // Seeds at or above a modulus are used as they are.
      send_request(ACT_RESEED, SEED_ALL_ONES);
      send_request(ACT_DRAW, 31'd0);
      send_request(ACT_DRAW, 31'd0);
      // A seed equal to the first modulus drives the first generator to zero for good.
      send_request(ACT_RESEED, SEED_FIRST_MOD);
      send_request(ACT_DRAW, 31'd0);
      send_request(ACT_DRAW, 31'd0);
      send_request(ACT_DRAW, 31'd0);
      send_request(ACT_RESEED, SEED_SECOND_MOD);
      send_request(ACT_DRAW, 31'd0);
      send_request(ACT_RESEED, SEED_WRAP);
      send_request(ACT_DRAW, 31'd0);
      send_request(ACT_RESEED, SECOND_START);
      send_request(ACT_DRAW, SEED_ALL_ONES);
      send_request(ACT_RESEED, 31'h5555_5555);
      send_request(ACT_RESEED, 31'h2AAA_AAAA);
      send_request(ACT_DRAW, 31'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 59) == 0) quiet = !quiet;
         if (i % 400 == 200) wait_for_drain();
         r = $urandom;
         if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 3) == 0) r = $urandom_range(0, 1000);
            send_request(ACT_RESEED, r[30:0]);
         end else begin
            send_request(ACT_DRAW, r[30:0]);
         end
      end
      req_valid <= 1'b0;

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("tb_combined_lcg_shuffle_rng: clean");
      end else begin
         $display("tb_combined_lcg_shuffle_rng: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("tb_combined_lcg_shuffle_rng: errors");
      $finish;
   end

endmodule
